/* rtl/mpps_pkg.sv */
package mpps_pkg;

    // Default size of the phase sequence.
    localparam int MAX_PHASES_DEFAULT = 16;

    // Table entries that the 4-bit entry index can reach.
    localparam int TABLE_ENTRIES = 16;

    // Field widths.
    localparam int NOW_W    = 64;
    localparam int PERIOD_W = 32;
    localparam int INDEX_W  = 4;
    localparam int SWITCH_W = 17;
    localparam int PHASE_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int ITER_W   = 10;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register reset values.
    localparam logic [COUNT_W-1:0]  PHASE_COUNT_RESET     = COUNT_W'(1);
    localparam logic [ITER_W-1:0]   ITERATION_LIMIT_RESET = ITER_W'(1000);
    localparam logic [PERIOD_W-1:0] PAUSE_DELAY_RESET     = PERIOD_W'(100000);

    // Command codes.
    localparam logic CMD_TIMER = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_COUNT     = 2'd0,
        CFG_ITERATION_LIMIT = 2'd1,
        CFG_PAUSE_DELAY     = 2'd2
    } t_cfg_index;

    // One input item.
    typedef struct packed {
        logic                cmd;
        logic [NOW_W-1:0]    now_time;
        logic [PERIOD_W-1:0] period_ticks;
        logic [INDEX_W-1:0]  entry_index;
        logic [SWITCH_W-1:0] switch_time_value;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [NOW_W-1:0]   next_time;
        logic [PHASE_W-1:0] apply_phase;
        logic               paused;
    } t_out_item;

    // Write request into the switch time table.
    typedef struct packed {
        logic                en;
        logic [INDEX_W-1:0]  index;
        logic [SWITCH_W-1:0] value;
    } t_table_wr;

endpackage

/* rtl/mpps_stream_if.sv */
interface mpps_stream_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

/* rtl/mpps_switch_table.sv */
module mpps_switch_table #(
    parameter int MAX_PHASES = mpps_pkg::MAX_PHASES_DEFAULT,
    localparam int POS_W = $clog2(MAX_PHASES)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mpps_pkg::t_table_wr                 i_wr,
    input  logic [POS_W-1:0]                    i_rd_pos,
    output logic [mpps_pkg::SWITCH_W-1:0]       o_rd_value
);
    import mpps_pkg::*;

    // Only entries that the entry index can address are stored; the rest read as zero.
    localparam int DEPTH = (MAX_PHASES < TABLE_ENTRIES) ? MAX_PHASES : TABLE_ENTRIES;
    localparam int IDX_W = $clog2(DEPTH);

    logic [SWITCH_W-1:0] r_entry [DEPTH];

    // Table writes; writes beyond the table are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_entry[i] <= '0;
            end
        end else if (i_wr.en && (int'(i_wr.index) < DEPTH)) begin
            r_entry[i_wr.index[IDX_W-1:0]] <= i_wr.value;
        end
    end

    // Read of the entry for the current phase position.
    always_comb begin
        if (int'(i_rd_pos) < DEPTH) begin
            o_rd_value = r_entry[i_rd_pos[IDX_W-1:0]];
        end else begin
            o_rd_value = '0;
        end
    end

endmodule

/* rtl/multi_phase_pwm_scheduler_unit.sv */
// Multi-phase PWM scheduler. Command items either write one Q16 switch time into
// the phase table (no result) or act as timer events, each of which returns one
// result: the phase whose pin states apply now and the absolute tick time of the
// next toggle, start + ((iteration << 16) + switch) * period >> 16, modulo 2^64.
// A zero period returns now plus the pause delay with the paused flag set. Items
// are taken one per cycle unless the input stalls; each passes an input register
// and then a result register before it is presented, and transfers out once the
// consumer is ready. A single multiply-add stage sits between the two registers,
// so only a result held back by the consumer slows the input. The user must write
// configuration only while idle; the block itself does not enforce this.
module multi_phase_pwm_scheduler_unit #(
    parameter int MAX_PHASES = mpps_pkg::MAX_PHASES_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mpps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mpps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mpps_stream_if.sink                       i_cmd_stream,
    mpps_stream_if.source                     o_result_stream
);
    import mpps_pkg::*;

    localparam int POS_W   = $clog2(MAX_PHASES);
    localparam int CLOG_CW = $clog2(MAX_PHASES + 1);
    localparam int CNT_W   = (CLOG_CW > COUNT_W) ? CLOG_CW : COUNT_W;
    localparam int MFRAC_W = ITER_W + FRAC_W + 1;
    localparam int PROD_W  = MFRAC_W + PERIOD_W;

    // Configuration registers.
    logic [COUNT_W-1:0]  r_phase_count;
    logic [ITER_W-1:0]   r_iteration_limit;
    logic [PERIOD_W-1:0] r_pause_delay;

    // Scheduler state.
    logic [POS_W-1:0]    r_phase_pos;
    logic [ITER_W-1:0]   r_cycle_iter;
    logic [NOW_W-1:0]    r_start_time;
    logic [PERIOD_W-1:0] r_active_period;

    // Input and result registers.
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic                w_advance;
    logic                w_timer;
    logic                w_paused;
    logic                w_anchor;
    logic [CNT_W-1:0]    w_count;
    logic [CNT_W-1:0]    w_pos_ext;
    logic [CNT_W-1:0]    w_pos_inc;
    logic [CNT_W-1:0]    w_applied;
    logic [SWITCH_W-1:0] w_switch;
    logic [NOW_W-1:0]    w_start;
    logic [ITER_W-1:0]   w_iter;
    logic [PERIOD_W-1:0] w_period;
    logic [MFRAC_W-1:0]  w_frac;
    logic [PROD_W-1:0]   w_prod;
    t_table_wr           w_table_wr;
    t_out_item           n_out;
    logic [POS_W-1:0]    n_phase_pos;
    logic [ITER_W-1:0]   n_cycle_iter;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_count     <= PHASE_COUNT_RESET;
            r_iteration_limit <= ITERATION_LIMIT_RESET;
            r_pause_delay     <= PAUSE_DELAY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PHASE_COUNT:     r_phase_count     <= i_cfg_data[COUNT_W-1:0];
                CFG_ITERATION_LIMIT: r_iteration_limit <= i_cfg_data[ITER_W-1:0];
                CFG_PAUSE_DELAY:     r_pause_delay     <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // The registered item moves on when it needs no result slot or the slot frees up.
    assign w_advance = r_in_valid
                    && ((r_in.cmd == CMD_WRITE) || !r_out_valid || o_result_stream.ready);
    assign i_cmd_stream.ready = !r_in_valid || w_advance;
    assign w_timer  = (r_in.cmd == CMD_TIMER);
    assign w_paused = (r_in.period_ticks == '0);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd_stream.ready) begin
            r_in_valid <= i_cmd_stream.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_stream.ready && i_cmd_stream.valid) begin
            r_in <= i_cmd_stream.data;
        end
    end

    // Table write on a write command.
    always_comb begin
        w_table_wr.en    = w_advance && (r_in.cmd == CMD_WRITE);
        w_table_wr.index = r_in.entry_index;
        w_table_wr.value = r_in.switch_time_value;
    end

    mpps_switch_table #(
        .MAX_PHASES (MAX_PHASES)
    ) u_switch_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_table_wr),
        .i_rd_pos   (r_phase_pos),
        .o_rd_value (w_switch)
    );

    // Effective phase count: zero acts as one, clamped to the table size.
    always_comb begin
        w_count = CNT_W'(r_phase_count);
        if (w_count == '0) begin
            w_count = CNT_W'(1);
        end
        if (w_count > CNT_W'(MAX_PHASES)) begin
            w_count = CNT_W'(MAX_PHASES);
        end
    end

    // Re-anchor at phase zero on a period change or when the iteration limit is reached.
    assign w_anchor = (r_phase_pos == '0)
                   && ((r_active_period != r_in.period_ticks)
                       || (r_cycle_iter >= r_iteration_limit));
    assign w_start  = w_anchor ? r_in.now_time     : r_start_time;
    assign w_iter   = w_anchor ? '0                : r_cycle_iter;
    assign w_period = w_anchor ? r_in.period_ticks : r_active_period;

    // Toggle time: one multiply and one wide add.
    assign w_frac = {1'b0, w_iter, {FRAC_W{1'b0}}} + MFRAC_W'(w_switch);
    assign w_prod = PROD_W'(w_frac) * PROD_W'(w_period);

    // Phase bookkeeping: the cycle ends once the position reaches the count.
    assign w_pos_ext = CNT_W'(r_phase_pos);
    assign w_pos_inc = w_pos_ext + CNT_W'(1);
    assign w_applied = (r_phase_pos == '0) ? (w_count - CNT_W'(1)) : (w_pos_ext - CNT_W'(1));

    always_comb begin
        if (w_pos_inc >= w_count) begin
            n_phase_pos  = '0;
            n_cycle_iter = w_iter + ITER_W'(1);
        end else begin
            n_phase_pos  = w_pos_inc[POS_W-1:0];
            n_cycle_iter = w_iter;
        end
    end

    // Result of a timer event.
    always_comb begin
        if (w_paused) begin
            n_out.next_time   = r_in.now_time + NOW_W'(r_pause_delay);
            n_out.apply_phase = '0;
            n_out.paused      = 1'b1;
        end else begin
            n_out.next_time   = w_start + NOW_W'(w_prod >> FRAC_W);
            n_out.apply_phase = w_applied[PHASE_W-1:0];
            n_out.paused      = 1'b0;
        end
    end

    // State update on an unpaused timer event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_pos     <= '0;
            r_cycle_iter    <= '0;
            r_start_time    <= '0;
            r_active_period <= '0;
        end else if (w_advance && w_timer && !w_paused) begin
            r_phase_pos     <= n_phase_pos;
            r_cycle_iter    <= n_cycle_iter;
            r_start_time    <= w_start;
            r_active_period <= w_period;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_timer) begin
            r_out_valid <= 1'b1;
        end else if (o_result_stream.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_timer) begin
            r_out <= n_out;
        end
    end

    assign o_result_stream.valid = r_out_valid;
    assign o_result_stream.data  = r_out;

endmodule
